### rtl/cv3_pkg.sv
// ----------------------------------------------------------------------------
// cv3_pkg
// Shared types, widths and constants of the 3x3 pixel stream convolver.
// ----------------------------------------------------------------------------
package cv3_pkg;

	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int DEF_MAX_HEIGHT  = 1024;
	localparam int DEF_COEFF_BITS  = 16;

	localparam int PIXEL_BITS      = 8;
	localparam int KERNEL_SIZE     = 3;
	localparam int TAPS            = KERNEL_SIZE * KERNEL_SIZE;
	localparam int SLOT_BITS       = 16;
	localparam int FRAC_BITS       = 8;
	localparam int CFG_DIM_BITS    = 11;
	localparam int KERNEL_ROW_BITS = SLOT_BITS * KERNEL_SIZE;
	localparam int CFG_DATA_BITS   = KERNEL_ROW_BITS;
	localparam int CFG_INDEX_BITS  = 3;

	typedef logic [PIXEL_BITS-1:0] pixel_t;
	typedef pixel_t [TAPS-1:0] window_t;
	typedef logic [KERNEL_ROW_BITS-1:0] kernel_row_t;
	typedef kernel_row_t [KERNEL_SIZE-1:0] kernel_t;

	localparam pixel_t PIXEL_MAX = 8'd255;

	localparam logic [CFG_DIM_BITS-1:0] RST_FRAME_WIDTH  = 11'd640;
	localparam logic [CFG_DIM_BITS-1:0] RST_FRAME_HEIGHT = 11'd480;
	localparam kernel_row_t RST_KERNEL_TOP    = 48'h0;
	localparam kernel_row_t RST_KERNEL_MID    = 48'h0000_0100_0000;
	localparam kernel_row_t RST_KERNEL_BOTTOM = 48'h0;

	typedef enum logic [0:0] {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT  = 3'd1,
		REG_KERNEL_TOP    = 3'd2,
		REG_KERNEL_MID    = 3'd3,
		REG_KERNEL_BOTTOM = 3'd4
	} cfg_reg_t;

endpackage

### rtl/cv3_ifs.sv
// ----------------------------------------------------------------------------
// cv3 channel interfaces
// Pixel input, pixel output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface cv3_pix_in_if import cv3_pkg::*; ();
	logic   valid;
	logic   ready;
	op_t    operation;
	pixel_t pixel_in;

	modport source (output valid, output operation, output pixel_in, input ready);
	modport sink (input valid, input operation, input pixel_in, output ready);
endinterface

interface cv3_pix_out_if import cv3_pkg::*; ();
	logic   valid;
	logic   ready;
	pixel_t pixel_out;
	logic   last_of_frame;

	modport source (output valid, output pixel_out, output last_of_frame, input ready);
	modport sink (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

interface cv3_cfg_if import cv3_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] reg_index;
	logic [CFG_DATA_BITS-1:0]  wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

### rtl/cv3_line_store.sv
// ----------------------------------------------------------------------------
// cv3_line_store
// Two line memories (rows y-2 and y-1), one write port shared by both,
// registered reads at the column address plus a last-column read on the
// older row.
// ----------------------------------------------------------------------------
module cv3_line_store import cv3_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  logic [$clog2(MAX_WIDTH)-1:0] last_addr,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input  pixel_t                       wr_older,
	input  pixel_t                       wr_newer,
	output pixel_t                       rd_older_q,
	output pixel_t                       rd_newer_q,
	output pixel_t                       rd_last_q
);

	pixel_t older_mem [MAX_WIDTH];
	pixel_t newer_mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			older_mem[wr_addr] <= wr_older;
			newer_mem[wr_addr] <= wr_newer;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_older_q <= older_mem[rd_addr];
			rd_last_q  <= older_mem[last_addr];
			rd_newer_q <= newer_mem[rd_addr];
		end
	end

endmodule

### rtl/cv3_rem_unit.sv
// ----------------------------------------------------------------------------
// cv3_rem_unit
// Bit-serial remainder of the pending count by the frame width, one
// dividend bit per cycle. Restarts on every start pulse.
// ----------------------------------------------------------------------------
module cv3_rem_unit import cv3_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [$clog2(MAX_WIDTH+3)-1:0]   dividend,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]   divisor,
	output logic                             busy,
	output logic                             done,
	output logic [$clog2(MAX_WIDTH)-1:0]     rem
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int PW    = $clog2(MAX_WIDTH + 3);
	localparam int CNT_W = $clog2(PW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PW-1:0]    dsh_q;
	logic [CW-1:0]    rem_q;
	logic [CW:0]      r2;
	logic [CW:0]      rn;

	always_comb begin
		r2 = {rem_q, dsh_q[PW-1]};
		if (r2 >= (CW+1)'(divisor)) begin
			rn = r2 - (CW+1)'(divisor);
		end else begin
			rn = r2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dsh_q  <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dsh_q  <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= CW'(rn);
			dsh_q <= dsh_q << 1;
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(PW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign busy = busy_q | done_q;
	assign done = done_q;
	assign rem  = rem_q;

endmodule

### rtl/cv3_mac.sv
// ----------------------------------------------------------------------------
// cv3_mac
// Nine registered tap products of the flipped kernel, then the sum,
// truncation of the fraction and clamp to 0..255.
// ----------------------------------------------------------------------------
module cv3_mac import cv3_pkg::*; #(
	parameter int COEFF_BITS = DEF_COEFF_BITS
) (
	input  logic    clk,
	input  logic    load,
	input  window_t win,
	input  kernel_t kern,
	output pixel_t  result
);

	localparam int PROD_W = COEFF_BITS + PIXEL_BITS + 1;
	localparam int SUM_W  = PROD_W + 4;
	localparam int SH_W   = SUM_W - FRAC_BITS;

	logic signed [PROD_W-1:0] wt_ext [TAPS];
	logic signed [PROD_W-1:0] px_ext [TAPS];
	logic signed [PROD_W-1:0] prod_s2 [TAPS];
	logic signed [SUM_W-1:0]  acc;
	logic        [SH_W-1:0]   sh;

	// tap (i,j) meets the pixel mirrored through the window centre
	always_comb begin
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			for (int j = 0; j < KERNEL_SIZE; j++) begin
				wt_ext[i*KERNEL_SIZE+j] =
					PROD_W'($signed(kern[i][SLOT_BITS*j +: COEFF_BITS]));
				px_ext[i*KERNEL_SIZE+j] = PROD_W'(
					win[(KERNEL_SIZE-1-i)*KERNEL_SIZE + (KERNEL_SIZE-1-j)]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < TAPS; k++) begin
				prod_s2[k] <= wt_ext[k] * px_ext[k];
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int k = 0; k < TAPS; k++) begin
			acc = acc + SUM_W'(prod_s2[k]);
		end
		sh = acc[SUM_W-1:FRAC_BITS];
		if (acc[SUM_W-1]) begin
			result = '0;
		end else if (|sh[SH_W-1:PIXEL_BITS]) begin
			result = PIXEL_MAX;
		end else begin
			result = sh[PIXEL_BITS-1:0];
		end
	end

endmodule

### rtl/conv3x3_pixel_stream.sv
// ----------------------------------------------------------------------------
// conv3x3_pixel_stream
// Streaming 3x3 convolution of raster grey pixels, border pass-through,
// drain items flush the tail of a frame.
// Path: the item that releases a result passes the line store read, the tap
//   products and the output register, in that order.
// Throughput: one item per cycle, pixels and drains alike, while the output is taken.
// After reset and after a frame_width or frame_height write the input is
//   held off while the bit-serial remainder unit rebuilds the drain column.
// ----------------------------------------------------------------------------
module conv3x3_pixel_stream import cv3_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int COEFF_BITS = DEF_COEFF_BITS
) (
	input logic           clk,
	input logic           arst_n,
	cv3_pix_in_if.sink    pix_in,
	cv3_pix_out_if.source pix_out,
	cv3_cfg_if.sink       cfg
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int DW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int PW = $clog2(MAX_WIDTH + 3);
	localparam int TW = DW + HW;

	// configuration
	logic [CFG_DIM_BITS-1:0] fw_q;
	logic [CFG_DIM_BITS-1:0] fh_q;
	kernel_t                 kern_q;
	logic                    cfg_wr;
	logic                    geo_wr;
	logic [DW-1:0]           w_c;
	logic [HW-1:0]           h_c;
	logic [TW-1:0]           total_q;

	// raster state
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [PW-1:0] pend_q;
	logic [CW-1:0] om_q;
	window_t       win_q;
	window_t       win_nx;

	// accept side
	logic          accept;
	logic          is_drain;
	logic          tail;
	logic          enter;
	logic [PW-1:0] p0;
	logic [PW-1:0] p1;
	logic          emit_px;
	logic [CW-1:0] om0;
	logic [DW-1:0] om_inc;
	logic [CW-1:0] om1;
	logic [DW-1:0] col_inc;
	logic [HW-1:0] row_inc;
	logic [CW-1:0] w_last;
	logic          over_total;
	logic [CW-1:0] ox;
	logic          sel_new;
	logic [CW-1:0] addr_a;
	logic          interior;
	logic          fwd_a;
	logic          fwd_e;

	// remainder unit
	logic          rem_busy;
	logic          rem_done;
	logic [CW-1:0] rem_val;

	// stage 1: line store data
	logic          v_s1;
	logic          drain_s1;
	logic          emit_s1;
	logic [CW-1:0] ix_s1;
	pixel_t        px_s1;
	logic          fa_s1;
	logic          fe_s1;
	pixel_t        fv_s1;
	pixel_t        fn_s1;
	logic          is0_s1;
	logic          int_s1;
	logic          sel_s1;
	logic          last_s1;
	pixel_t        rd_older;
	pixel_t        rd_newer;
	pixel_t        rd_last;
	pixel_t        old_eff;
	pixel_t        new_eff;
	pixel_t        edge_eff;
	pixel_t        pass_s1;
	logic          conv_s1;
	logic          s1_adv;

	// stage 2: products
	logic   v_s2;
	logic   conv_s2;
	pixel_t pass_s2;
	logic   last_s2;
	pixel_t mac_val;
	logic   s2_adv;
	logic   s2_free;

	// output register
	logic   out_v_q;
	pixel_t out_pix_q;
	logic   out_last_q;
	logic   out_free;

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign geo_wr    = cfg_wr && (cfg.reg_index == REG_FRAME_WIDTH ||
		cfg.reg_index == REG_FRAME_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q      <= RST_FRAME_WIDTH;
			fh_q      <= RST_FRAME_HEIGHT;
			kern_q[0] <= RST_KERNEL_TOP;
			kern_q[1] <= RST_KERNEL_MID;
			kern_q[2] <= RST_KERNEL_BOTTOM;
		end else if (cfg_wr) begin
			case (cfg.reg_index)
				REG_FRAME_WIDTH:   fw_q      <= cfg.wr_data[CFG_DIM_BITS-1:0];
				REG_FRAME_HEIGHT:  fh_q      <= cfg.wr_data[CFG_DIM_BITS-1:0];
				REG_KERNEL_TOP:    kern_q[0] <= cfg.wr_data;
				REG_KERNEL_MID:    kern_q[1] <= cfg.wr_data;
				REG_KERNEL_BOTTOM: kern_q[2] <= cfg.wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (fw_q == '0) begin
			w_c = DW'(1);
		end else if (int'(fw_q) > MAX_WIDTH) begin
			w_c = DW'(MAX_WIDTH);
		end else begin
			w_c = DW'(fw_q);
		end
		if (fh_q == '0) begin
			h_c = HW'(1);
		end else if (int'(fh_q) > MAX_HEIGHT) begin
			h_c = HW'(MAX_HEIGHT);
		end else begin
			h_c = HW'(fh_q);
		end
	end

	always_ff @(posedge clk) begin
		total_q <= TW'(w_c) * TW'(h_c);
	end

	// pending mod width, rebuilt after geometry changes
	cv3_rem_unit #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (geo_wr),
		.dividend (pend_q),
		.divisor  (w_c),
		.busy     (rem_busy),
		.done     (rem_done),
		.rem      (rem_val)
	);

	// ---------------- accept side ----------------
	assign is_drain = (pix_in.operation == OP_DRAIN);
	assign tail     = (col_q == '0) && (row_q == '0) && (pend_q != '0);
	assign enter    = !is_drain || tail;
	assign pix_in.ready = !rem_busy && !geo_wr && (!v_s1 || s1_adv);
	assign accept   = pix_in.valid && pix_in.ready;

	always_comb begin
		p0      = tail ? '0 : pend_q;
		p1      = p0 + PW'(1);
		emit_px = p1 > (PW'(w_c) + PW'(1));
		om0     = tail ? '0 : om_q;
		om_inc  = DW'(om0) + DW'(1);
		om1     = (om_inc == w_c) ? '0 : CW'(om_inc);
		col_inc = DW'(col_q) + DW'(1);
		row_inc = HW'(row_q) + HW'(1);
		w_last  = CW'(w_c - DW'(1));

		// drain position: column (-pending) mod width, last row when pending <= width
		over_total = TW'(pend_q) > total_q;
		if (over_total || om_q == '0) begin
			ox = '0;
		end else begin
			ox = CW'(w_c - DW'(om_q));
		end
		sel_new = over_total ? (h_c == HW'(1)) : (pend_q <= PW'(w_c));

		addr_a   = is_drain ? ox : col_q;
		interior = (col_q >= CW'(2)) && (DW'(col_q) < w_c) &&
			(row_q >= RW'(2)) && (HW'(row_q) < h_c);

		// item in stage 1 writes its column at this same edge
		fwd_a = v_s1 && !drain_s1 && (ix_s1 == addr_a);
		fwd_e = v_s1 && !drain_s1 && (ix_s1 == w_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
			om_q   <= '0;
		end else if (rem_done) begin
			om_q <= rem_val;
		end else if (accept) begin
			if (!is_drain) begin
				pend_q <= emit_px ? p0 : p1;
				om_q   <= emit_px ? om0 : om1;
				if (col_inc >= w_c) begin
					col_q <= '0;
					row_q <= (row_inc >= h_c) ? '0 : RW'(row_inc);
				end else begin
					col_q <= CW'(col_inc);
				end
			end else if (tail) begin
				pend_q <= pend_q - PW'(1);
				om_q   <= (om_q == '0) ? w_last : om_q - CW'(1);
			end
		end
	end

	// ---------------- line stores ----------------
	cv3_line_store #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_lines (
		.clk        (clk),
		.rd_en      (accept && enter),
		.rd_addr    (addr_a),
		.last_addr  (w_last),
		.wr_en      (s1_adv && !drain_s1),
		.wr_addr    (ix_s1),
		.wr_older   (new_eff),
		.wr_newer   (px_s1),
		.rd_older_q (rd_older),
		.rd_newer_q (rd_newer),
		.rd_last_q  (rd_last)
	);

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= enter;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			drain_s1 <= is_drain;
			emit_s1  <= is_drain || emit_px;
			ix_s1    <= addr_a;
			px_s1    <= pix_in.pixel_in;
			fa_s1    <= fwd_a;
			fe_s1    <= fwd_e;
			fv_s1    <= new_eff;
			fn_s1    <= px_s1;
			is0_s1   <= (col_q == '0);
			int_s1   <= interior;
			sel_s1   <= sel_new;
			last_s1  <= is_drain && (pend_q == PW'(1));
		end
	end

	always_comb begin
		old_eff  = fa_s1 ? fv_s1 : rd_older;
		new_eff  = fa_s1 ? fn_s1 : rd_newer;
		edge_eff = fe_s1 ? fv_s1 : rd_last;

		for (int r = 0; r < KERNEL_SIZE; r++) begin
			win_nx[r*KERNEL_SIZE+0] = win_q[r*KERNEL_SIZE+1];
			win_nx[r*KERNEL_SIZE+1] = win_q[r*KERNEL_SIZE+2];
		end
		win_nx[2] = old_eff;
		win_nx[5] = new_eff;
		win_nx[8] = px_s1;

		if (drain_s1) begin
			pass_s1 = sel_s1 ? new_eff : old_eff;
		end else if (is0_s1) begin
			pass_s1 = edge_eff;
		end else begin
			pass_s1 = win_nx[4];
		end
		conv_s1 = !drain_s1 && !is0_s1 && int_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_adv && !drain_s1) begin
			win_q <= win_nx;
		end
	end

	assign s1_adv = v_s1 && (!emit_s1 || s2_free);

	// ---------------- stage 2 ----------------
	cv3_mac #(
		.COEFF_BITS (COEFF_BITS)
	) u_mac (
		.clk    (clk),
		.load   (s1_adv && emit_s1),
		.win    (win_nx),
		.kern   (kern_q),
		.result (mac_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			v_s2 <= 1'b1;
		end else if (s2_adv) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			conv_s2 <= conv_s1;
			pass_s2 <= pass_s1;
			last_s2 <= last_s1;
		end
	end

	assign s2_adv  = v_s2 && out_free;
	assign s2_free = !v_s2 || s2_adv;

	// ---------------- output register ----------------
	assign out_free = !out_v_q || pix_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s2_adv) begin
			out_v_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			out_pix_q  <= conv_s2 ? mac_val : pass_s2;
			out_last_q <= last_s2;
		end
	end

	assign pix_out.valid         = out_v_q;
	assign pix_out.pixel_out     = out_pix_q;
	assign pix_out.last_of_frame = out_last_q;

endmodule
